@@ rtl/sgtm_pkg.sv @@
`timescale 1ns / 1ps
package sgtm_pkg;
	localparam int unsigned ItemCount = 21;
	localparam int unsigned ValW = 18;
	localparam int unsigned IdxW = 5;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_OPENED  = 3'd1,
		EV_MOVED   = 3'd2,
		EV_CHANGED = 3'd3,
		EV_SAVE    = 3'd4,
		EV_DISCARD = 3'd5,
		EV_INVALID = 3'd6,
		EV_ACCESS  = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_LOAD  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_STICK_HIGH  = 3'd0,
		REG_STICK_LOW   = 3'd1,
		REG_CENTER_LOW  = 3'd2,
		REG_CENTER_HIGH = 3'd3,
		REG_HOLD_TIME   = 3'd4,
		REG_REPEAT      = 3'd5
	} reg_idx_t;

	localparam logic [ValW-1:0] Ladder [7] = '{18'd25, 18'd100, 18'd200, 18'd400,
		18'd500, 18'd600, 18'd1000};

	function automatic logic [ValW-1:0] clamp_step(input logic [ValW-1:0] v,
		input logic up, input logic [ValW-1:0] lo, input logic [ValW-1:0] hi);
		logic [ValW:0] x;
		begin
			if (up) x = {1'b0, v} + 19'd1;
			else if (v == '0) x = '0;
			else x = {1'b0, v} - 19'd1;
			if (!up && v == '0) x = {1'b0, lo};
			if (x < {1'b0, lo}) x = {1'b0, lo};
			if (x > {1'b0, hi}) x = {1'b0, hi};
			return x[ValW-1:0];
		end
	endfunction

	// v mod 6 from v mod 2 and v mod 3; 4 = 1 mod 3, so mod 3 is a sum of 2-bit digits
	function automatic logic [2:0] mod6(input logic [ValW-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [1:0] r3;
		logic [2:0] r;
		begin
			s = '0;
			for (int i = 0; i < ValW / 2; i++) s = s + 5'(v[2*i +: 2]);
			t = 3'(s[1:0]) + 3'(s[3:2]) + {2'b00, s[4]};
			if (t >= 3'd6) r3 = 2'(t - 3'd6);
			else if (t >= 3'd3) r3 = 2'(t - 3'd3);
			else r3 = t[1:0];
			unique case ({v[0], r3})
				3'b000: r = 3'd0;
				3'b001: r = 3'd4;
				3'b010: r = 3'd2;
				3'b100: r = 3'd3;
				3'b101: r = 3'd1;
				3'b110: r = 3'd5;
				default: r = 3'd0;
			endcase
			return r;
		end
	endfunction

	// one step of the selected item's value
	function automatic logic [ValW-1:0] step_value(input logic [IdxW-1:0] it,
		input logic [ValW-1:0] v, input logic up);
		logic [2:0] k;
		logic [2:0] m;
		logic [2:0] b;
		begin
			k = 3'd6;
			for (int i = 5; i >= 0; i--) begin
				if (Ladder[i] >= v) k = 3'(i);
			end
			m = 3'd0;
			b = 3'd0;
			unique case (it)
				5'd0, 5'd1, 5'd4, 5'd5, 5'd8, 5'd9:
					return clamp_step(v, up, 18'd0, 18'd200000);
				5'd2, 5'd6, 5'd10: return clamp_step(v, up, 18'd0, 18'd5000);
				5'd3, 5'd7, 5'd11: return clamp_step(v, up, 18'd0, 18'd1000);
				5'd12, 5'd13, 5'd14: return clamp_step(v, up, 18'd100, 18'd1200);
				5'd15: return clamp_step(v, up, 18'd0, 18'd90);
				5'd16, 5'd17: return clamp_step(v, up, 18'd0, 18'd100);
				5'd18: begin
					// band is the full 18-bit value mod 6 and wraps within 0 to 5
					b = mod6(v);
					if (up) b = (b == 3'd5) ? 3'd0 : b + 3'd1;
					else b = (b == 3'd0) ? 3'd5 : b - 3'd1;
					return {15'd0, b};
				end
				5'd19: begin
					m = up ? v[2:0] + 3'd1 : v[2:0] + 3'd7;
					return {15'd0, m};
				end
				5'd20: begin
					if (up) k = (k == 3'd6) ? 3'd0 : k + 3'd1;
					else k = (k == 3'd0) ? 3'd6 : k - 3'd1;
					return Ladder[k];
				end
				default: return v;
			endcase
		end
	endfunction
endpackage

@@ rtl/stick_gesture_tuning_menu.sv @@
`timescale 1ns / 1ps
// Stick gesture tuning menu.
// Command channel: start with the item fields; accepted when start is high and
// busy is low. Each item gives exactly one result on done, one cycle wide, with
// event_code, menu_active, selected_index and value_out.
// Timing: an accepted item passes through S_READ, S_EXEC and S_POST; done is
// raised as the block returns to S_IDLE and busy drops with it, so the next
// item can be taken at the edge that ends the done cycle and not before. The
// steps follow the read-modify-write of the settings memory (read, compute and
// write, read back the selected entry, present).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// low while an item is in flight.
// Reset: thresholds and times return to defaults, menu closed, item 0. The
// settings memory holds no reset value and must be loaded before use.
// The receiver cannot stall: done is a one-cycle strobe.
module stick_gesture_tuning_menu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  operation,
	input  logic        frame_valid,
	input  logic [11:0] throttle_us,
	input  logic [11:0] roll_us,
	input  logic [11:0] pitch_us,
	input  logic [11:0] yaw_us,
	input  logic        arm_switch_on,
	input  logic        is_armed,
	input  logic [31:0] now_us,
	input  logic        osd_ready,
	input  logic [4:0]  entry_index,
	input  logic [17:0] entry_value,
	output logic [2:0]  event_code,
	output logic        menu_active,
	output logic [4:0]  selected_index,
	output logic [17:0] value_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_POST} state_t;

	state_t state_q;
	logic [11:0] hi_q, lo_q, clo_q, chi_q;
	logic [31:0] hold_t_q, rep_q;
	logic menu_q, ready_q, hold_q;
	logic [31:0] hold_start_q, last_q;
	logic [4:0] item_q;
	logic [17:0] vo_q;
	logic vsel_q;

	logic [1:0]  op_q;
	logic        fv_q, arm_q, armed_q, osd_q;
	logic [11:0] thr_q, rol_q, pit_q, yaw_q;
	logic [31:0] now_q;
	logic [4:0]  eidx_q;
	logic [17:0] eval_q;

	logic [17:0] mem [sgtm_pkg::ItemCount];
	logic [17:0] rd_q;
	logic [4:0]  rd_addr;
	logic        mem_we;
	logic [4:0]  wr_addr;
	logic [17:0] wr_data;

	logic idx_ok;
	assign idx_ok = eidx_q < 5'(sgtm_pkg::ItemCount);
	assign cfg_ready = !busy;
	assign busy = state_q != S_IDLE;
	assign rd_addr = (op_q == sgtm_pkg::OP_READ) ? eidx_q : item_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// frame decision, evaluated in S_EXEC with memory data available
	logic cen, combo, hold_done, rep_ok;
	logic [31:0] hstart;
	logic [2:0] ev;
	logic [4:0] nitem;
	logic [17:0] stepped;
	logic step_up;

	always_comb begin
		cen = thr_q >= clo_q && thr_q <= chi_q && rol_q >= clo_q && rol_q <= chi_q &&
			pit_q >= clo_q && pit_q <= chi_q && yaw_q >= clo_q && yaw_q <= chi_q;
		combo = !armed_q && !arm_q && thr_q >= hi_q && rol_q >= hi_q;
		hstart = hold_start_q;
		if (!hold_q) hstart = now_q;
		hold_done = (now_q - hstart) >= hold_t_q;
		rep_ok = (now_q - last_q) >= rep_q;
		step_up = rol_q >= hi_q;
		stepped = sgtm_pkg::step_value(item_q, rd_q, step_up);
		nitem = item_q;
		ev = sgtm_pkg::EV_NONE;
		if (!fv_q) ev = menu_q ? sgtm_pkg::EV_INVALID : sgtm_pkg::EV_NONE;
		else if (!menu_q) begin
			if (combo && hold_done && osd_q) ev = sgtm_pkg::EV_OPENED;
		end else if (ready_q && rep_ok) begin
			if (yaw_q >= hi_q) ev = sgtm_pkg::EV_SAVE;
			else if (yaw_q <= lo_q) ev = sgtm_pkg::EV_DISCARD;
			else if (pit_q >= hi_q) begin
				ev = sgtm_pkg::EV_MOVED;
				nitem = (item_q == 5'd0) ? 5'(sgtm_pkg::ItemCount - 1) : item_q - 5'd1;
			end else if (pit_q <= lo_q) begin
				ev = sgtm_pkg::EV_MOVED;
				nitem = (item_q == 5'(sgtm_pkg::ItemCount - 1)) ? 5'd0 : item_q + 5'd1;
			end else if (rol_q >= hi_q || rol_q <= lo_q) ev = sgtm_pkg::EV_CHANGED;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		wr_addr = eidx_q;
		wr_data = eval_q;
		if (state_q == S_EXEC) begin
			if (op_q == sgtm_pkg::OP_LOAD && idx_ok) mem_we = 1'b1;
			else if (op_q == sgtm_pkg::OP_FRAME && ev == sgtm_pkg::EV_CHANGED) begin
				mem_we = 1'b1;
				wr_addr = item_q;
				wr_data = stepped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hi_q <= 12'd1750; lo_q <= 12'd1250; clo_q <= 12'd1350; chi_q <= 12'd1650;
			hold_t_q <= 32'd800000; rep_q <= 32'd250000;
			menu_q <= 1'b0; ready_q <= 1'b0; hold_q <= 1'b0;
			hold_start_q <= '0; last_q <= '0; item_q <= '0;
			done <= 1'b0; event_code <= '0; vo_q <= '0; vsel_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sgtm_pkg::REG_STICK_HIGH:  hi_q <= cfg_data[11:0];
					sgtm_pkg::REG_STICK_LOW:   lo_q <= cfg_data[11:0];
					sgtm_pkg::REG_CENTER_LOW:  clo_q <= cfg_data[11:0];
					sgtm_pkg::REG_CENTER_HIGH: chi_q <= cfg_data[11:0];
					sgtm_pkg::REG_HOLD_TIME:   hold_t_q <= cfg_data;
					sgtm_pkg::REG_REPEAT:      rep_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_POST;
					event_code <= sgtm_pkg::EV_ACCESS;
					vo_q <= '0;
					vsel_q <= 1'b0;
					unique case (op_q)
						sgtm_pkg::OP_LOAD: if (idx_ok) vo_q <= eval_q;
						sgtm_pkg::OP_READ: if (idx_ok) vo_q <= rd_q;
						sgtm_pkg::OP_NOP: event_code <= sgtm_pkg::EV_NONE;
						sgtm_pkg::OP_FRAME: begin
							event_code <= ev;
							// selected entry is read back after the write
							vsel_q <= ev == sgtm_pkg::EV_OPENED || ev == sgtm_pkg::EV_MOVED ||
								ev == sgtm_pkg::EV_CHANGED;
							if (!fv_q || (!menu_q && !combo)) hold_q <= 1'b0;
							else if (!menu_q && !hold_q) begin
								hold_q <= 1'b1;
								hold_start_q <= now_q;
							end
							if (fv_q && menu_q && !ready_q && cen) ready_q <= 1'b1;
							unique case (ev)
								sgtm_pkg::EV_OPENED: begin
									menu_q <= 1'b1; ready_q <= 1'b0; item_q <= '0;
									last_q <= now_q;
								end
								sgtm_pkg::EV_SAVE, sgtm_pkg::EV_DISCARD,
								sgtm_pkg::EV_INVALID: begin
									menu_q <= 1'b0; ready_q <= 1'b0; hold_q <= 1'b0;
								end
								sgtm_pkg::EV_MOVED: begin
									item_q <= nitem; last_q <= now_q;
								end
								sgtm_pkg::EV_CHANGED: last_q <= now_q;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_POST: begin
					state_q <= S_IDLE;
					done <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= operation; fv_q <= frame_valid;
			thr_q <= throttle_us; rol_q <= roll_us; pit_q <= pitch_us; yaw_q <= yaw_us;
			arm_q <= arm_switch_on; armed_q <= is_armed; now_q <= now_us;
			osd_q <= osd_ready; eidx_q <= entry_index; eval_q <= entry_value;
		end
	end

	// outputs that follow state
	always_comb begin
		menu_active = menu_q;
		selected_index = item_q;
		value_out = vsel_q ? rd_q : vo_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("latency");
	assert property (@(posedge clk) disable iff (!arst_n)
		item_q < 5'(sgtm_pkg::ItemCount)) else $error("item range");
endmodule
